@@ rtl/bm3_pkg.sv @@
// ----------------------------------------------------------------------------
// bm3_pkg
// Shared types, constants and window functions of the 3x3 binary morphology.
// ----------------------------------------------------------------------------
package bm3_pkg;

    localparam int MASK_W  = 9;
    localparam int FRAME_W = 11;
    localparam int CFG_W   = 11;
    localparam int MAX_DIM = 1024;

    typedef enum logic [1:0] {
        CFG_MASK   = 2'd0,
        CFG_MODE   = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } bm3_cfg_idx_t;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic MODE_DILATE = 1'b0;
    localparam logic MODE_ERODE  = 1'b1;

    localparam logic [MASK_W-1:0] MASK_RESET  = 9'd186;
    localparam logic [FRAME_W-1:0] DIM_RESET  = 11'd64;

    // Status of one item as it leaves the scan stage.
    typedef struct packed {
        logic v;
        logic top_en;
        logic mid_en;
        logic col_first;
        logic emit;
        logic frame_end;
    } bm3_item_t;

    typedef struct packed {
        logic out_pixel;
        logic frame_end;
    } bm3_result_t;

    // Shifts the window one column left; the new column enters on the right.
    function automatic logic [MASK_W-1:0] bm3_shift(
        input logic [MASK_W-1:0] win,
        input logic              t,
        input logic              m,
        input logic              b
    );
        logic [MASK_W-1:0] nw;
        logic [2:0]        col;
        nw  = '0;
        col = {b, m, t};
        for (int r = 0; r < 3; r++)
        begin
            nw[r*3]     = win[r*3+1];
            nw[r*3+1]   = win[r*3+2];
            nw[r*3+2]   = col[r];
        end
        return nw;
    endfunction

    // Dilation uses the reflected element, erosion the element as given.
    function automatic logic bm3_morph(
        input logic [MASK_W-1:0] win,
        input logic [MASK_W-1:0] mask,
        input logic              erode
    );
        logic [MASK_W-1:0] rev;
        rev = '0;
        for (int i = 0; i < MASK_W; i++)
        begin
            rev[MASK_W-1-i] = win[i];
        end
        if (erode == MODE_ERODE)
        begin
            return ((win & mask) == mask);
        end
        return ((rev & mask) != '0);
    endfunction

endpackage

@@ rtl/bm3_ram.sv @@
// ----------------------------------------------------------------------------
// bm3_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module bm3_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bm3_scan.sv @@
// ----------------------------------------------------------------------------
// bm3_scan
// Raster position counters; issues the line store address of each item.
// ----------------------------------------------------------------------------
module bm3_scan
    import bm3_pkg::*;
#(
    parameter int MAX_LINE = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        restart,
    input  logic [FRAME_W-1:0]          frame_w,
    input  logic [FRAME_W-1:0]          frame_h,
    input  logic                        command,
    input  logic                        pixel,
    output logic [$clog2(MAX_LINE)-1:0] addr,
    output logic [FRAME_W-1:0]          row,
    output bm3_item_t                   item
);

    localparam int AW   = $clog2(MAX_LINE);
    localparam int CNTW = (AW + 1 > FRAME_W) ? AW + 1 : FRAME_W;

    logic [AW-1:0]      col_reg;
    logic [AW-1:0]      col_next;
    logic [FRAME_W-1:0] row_reg;
    logic [FRAME_W-1:0] row_next;
    logic               last_col;

    always_comb
    begin
        item.col_first = (col_reg == '0);
        item.mid_en    = (row_reg != '0);
        item.top_en    = (row_reg >= FRAME_W'(2));
        item.emit      = item.col_first ? item.top_en : item.mid_en;
        item.frame_end = item.col_first && (row_reg == frame_h + FRAME_W'(1));
        item.v         = (command == CMD_PIXEL) && (row_reg < frame_h) && pixel;
        last_col       = (CNTW'(col_reg) + CNTW'(1)) == CNTW'(frame_w);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (item.frame_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (last_col)
            begin
                col_next = '0;
                row_next = row_reg + FRAME_W'(1);
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign addr = col_reg;
    assign row  = row_reg;

endmodule

@@ rtl/bm3_win.sv @@
// ----------------------------------------------------------------------------
// bm3_win
// 3x3 window register, line store write-back data and morphology result.
// ----------------------------------------------------------------------------
module bm3_win
    import bm3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    input  bm3_item_t         item,
    input  logic [1:0]        line_data,
    input  logic [MASK_W-1:0] mask,
    input  logic              erode,
    output logic [1:0]        wr_data,
    output logic              push,
    output bm3_result_t       result
);

    logic [MASK_W-1:0] win_reg;
    logic [MASK_W-1:0] win_next;
    logic [MASK_W-1:0] cand;
    logic              top_bit;
    logic              mid_bit;

    always_comb
    begin
        top_bit = item.top_en & line_data[1];
        mid_bit = item.mid_en & line_data[0];
        if (item.col_first)
        begin
            cand     = bm3_shift(win_reg, 1'b0, 1'b0, 1'b0);
            win_next = bm3_shift('0, top_bit, mid_bit, item.v);
        end
        else
        begin
            win_next = bm3_shift(win_reg, top_bit, mid_bit, item.v);
            cand     = win_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (valid)
        begin
            win_reg <= win_next;
        end
    end

    assign wr_data          = {mid_bit, item.v};
    assign push             = valid && item.emit;
    assign result.out_pixel = bm3_morph(cand, mask, erode);
    assign result.frame_end = item.frame_end;

endmodule

@@ rtl/bm3_oq.sv @@
// ----------------------------------------------------------------------------
// bm3_oq
// Two-entry result queue between the window stage and the output channel.
// ----------------------------------------------------------------------------
module bm3_oq
    import bm3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  bm3_result_t push_data,
    input  logic        pop,
    output logic        not_empty,
    output bm3_result_t head,
    output logic [1:0]  count
);

    bm3_result_t entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

@@ rtl/binary_morphology_3x3_top.sv @@
// ----------------------------------------------------------------------------
// binary_morphology_3x3_top
// Streaming 3x3 binary dilation and erosion with two line stores.
// ----------------------------------------------------------------------------
// The block takes one pixel item per clock while in_stall is low and gives the
// morphology result of the pixel one line plus one pixel earlier, once the item
// that completes its window has passed the item register, through a two-entry
// output queue. Both previous lines live in one memory of MAX_LINE two-bit words
// that is read and written once per item, so that one read and one write per
// clock set the rate. Drain items push zero pixels; the last result of a frame
// carries frame_end. Writing the frame width or height restarts the frame. The
// line memory needs no clearing after reset.
module binary_morphology_3x3_top
    import bm3_pkg::*;
#(
    parameter int MAX_LINE = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic               pixel,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               out_pixel,
    output logic               frame_end
);

    localparam int AW  = $clog2(MAX_LINE);
    localparam int LIM = (MAX_LINE < MAX_DIM) ? MAX_LINE : MAX_DIM;

    logic [MASK_W-1:0]  mask_reg;
    logic               mode_reg;
    logic [FRAME_W-1:0] width_reg;
    logic [FRAME_W-1:0] height_reg;
    logic               restart;

    logic [FRAME_W-1:0] eff_w;
    logic [FRAME_W-1:0] eff_h;

    logic               accept;
    logic               pop;
    logic [2:0]         occupancy;
    logic [AW-1:0]      scan_addr;
    logic [FRAME_W-1:0] scan_row;
    bm3_item_t          scan_item;

    logic               s1_valid_reg;
    bm3_item_t          s1_item_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic               fwd_reg;
    logic [1:0]         fwd_data_reg;

    logic [1:0]         ram_rdata;
    logic [1:0]         line_data;
    logic [1:0]         wr_data;
    logic               push;
    bm3_result_t        result;
    bm3_result_t        head;
    logic [1:0]         oq_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= MASK_RESET;
            mode_reg   <= MODE_DILATE;
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (bm3_cfg_idx_t'(cfg_index))
                CFG_MASK:   mask_reg   <= cfg_data[MASK_W-1:0];
                CFG_MODE:   mode_reg   <= cfg_data[0];
                CFG_WIDTH:  width_reg  <= cfg_data[FRAME_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[FRAME_W-1:0];
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    assign restart = cfg_write && ((bm3_cfg_idx_t'(cfg_index) == CFG_WIDTH) ||
                                   (bm3_cfg_idx_t'(cfg_index) == CFG_HEIGHT));

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = FRAME_W'(1);
        end
        else if (width_reg > FRAME_W'(LIM))
        begin
            eff_w = FRAME_W'(LIM);
        end
        else
        begin
            eff_w = width_reg;
        end
        if (height_reg == '0)
        begin
            eff_h = FRAME_W'(1);
        end
        else if (height_reg > FRAME_W'(MAX_DIM))
        begin
            eff_h = FRAME_W'(MAX_DIM);
        end
        else
        begin
            eff_h = height_reg;
        end
    end

    assign pop       = out_valid && !out_stall;
    assign occupancy = {1'b0, oq_count} + {2'b00, s1_valid_reg} - {2'b00, pop};
    assign in_stall  = (occupancy >= 3'd2);
    assign accept    = in_valid && !in_stall;

    bm3_scan #(
        .MAX_LINE (MAX_LINE)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .restart (restart),
        .frame_w (eff_w),
        .frame_h (eff_h),
        .command (command),
        .pixel   (pixel),
        .addr    (scan_addr),
        .row     (scan_row),
        .item    (scan_item)
    );

    bm3_ram #(
        .WIDTH (2),
        .DEPTH (MAX_LINE)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (wr_data),
        .re    (accept),
        .raddr (scan_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                fwd_reg <= s1_valid_reg && (s1_addr_reg == scan_addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg  <= scan_item;
            s1_addr_reg  <= scan_addr;
            fwd_data_reg <= wr_data;
        end
    end

    // A store to the entry being read in the same cycle bypasses the memory.
    assign line_data = fwd_reg ? fwd_data_reg : ram_rdata;

    bm3_win u_win (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (s1_valid_reg),
        .item      (s1_item_reg),
        .line_data (line_data),
        .mask      (mask_reg),
        .erode     (mode_reg),
        .wr_data   (wr_data),
        .push      (push),
        .result    (result)
    );

    bm3_oq u_oq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .pop       (pop),
        .not_empty (out_valid),
        .head      (head),
        .count     (oq_count)
    );

    assign out_pixel = head.out_pixel;
    assign frame_end = head.frame_end;

`ifndef SYNTHESIS
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (oq_count != 2'd2 || pop))
        else $error("Result pushed into a full output queue.");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && scan_item.frame_end && !restart) |=>
            (scan_row == '0 && scan_addr == '0))
        else $error("Scan position not cleared after the last item of a frame.");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_row <= eff_h + FRAME_W'(1))
        else $error("Row counter ran past the end of the frame.");

    a_forward_only_same: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg && s1_addr_reg != scan_addr) |=> !fwd_reg)
        else $error("Forwarding selected for a different line address.");
`endif

endmodule

@@ dv/tb_binary_morphology_3x3_top.sv @@
// ----------------------------------------------------------------------------
// tb_binary_morphology_3x3_top
// Self-checking testbench for the streaming 3x3 binary dilation and erosion.
// A model kept inside the testbench follows the accepted items and the
// register writes, predicts each result and its frame end, and checks the
// results in order. Directed frames cover the reset setting, full and empty
// structuring elements, early drains, surplus pixels, zero width and height
// and a one-pixel-wide frame. A long output hold-off fills the block, and
// small random frames run under random gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_binary_morphology_3x3_top;
    import bm3_pkg::*;

    localparam int unsigned LINE_LIMIT    = MAX_DIM;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned RANDOM_ITEMS  = 700;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned MAX_GAP       = 16;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               command;
    logic               pixel;
    logic               out_valid;
    logic               out_stall;
    logic               out_pixel;
    logic               frame_end;

    logic [MASK_W-1:0]  reg_mask;
    logic               reg_mode;
    logic [FRAME_W-1:0] reg_width;
    logic [FRAME_W-1:0] reg_height;
    logic               line_prev [LINE_LIMIT];
    logic               line_older [LINE_LIMIT];
    logic [MASK_W-1:0]  window_bits;
    int unsigned        next_col;
    int unsigned        next_row;
    int unsigned        results_given;
    bm3_result_t        expected_pixels [$];

    bit                 steady = 1'b0;
    int unsigned        hold_off_cycles = 0;
    int unsigned        mismatch_count = 0;
    int unsigned        items_sent = 0;
    int unsigned        cycle_count = 0;

    binary_morphology_3x3_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_pixel (out_pixel),
        .frame_end (frame_end)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int unsigned active_width();
        if (reg_width == 0)
        begin
            return 1;
        end
        if (reg_width > LINE_LIMIT)
        begin
            return LINE_LIMIT;
        end
        return reg_width;
    endfunction

    function automatic int unsigned active_height();
        if (reg_height == 0)
        begin
            return 1;
        end
        if (reg_height > MAX_DIM)
        begin
            return MAX_DIM;
        end
        return reg_height;
    endfunction

    function automatic int unsigned frame_items();
        return (active_height() + 1) * active_width() + 1;
    endfunction

    function automatic void restart_frame();
        window_bits   = '0;
        next_col      = 0;
        next_row      = 0;
        results_given = 0;
    endfunction

    function automatic void reset_prediction();
        reg_mask   = MASK_RESET;
        reg_mode   = MODE_DILATE;
        reg_width  = DIM_RESET;
        reg_height = DIM_RESET;
        foreach (line_prev[i])
        begin
            line_prev[i]  = 1'b0;
            line_older[i] = 1'b0;
        end
        restart_frame();
    endfunction

    function automatic void apply_register(logic [1:0] idx, logic [CFG_W-1:0] data);
        case (bm3_cfg_idx_t'(idx))
            CFG_MASK:
            begin
                reg_mask = data[MASK_W-1:0];
            end
            CFG_MODE:
            begin
                reg_mode = data[0];
            end
            CFG_WIDTH:
            begin
                reg_width = data[FRAME_W-1:0];
                restart_frame();
            end
            CFG_HEIGHT:
            begin
                reg_height = data[FRAME_W-1:0];
                restart_frame();
            end
            default:
            begin
            end
        endcase
    endfunction

    // The window holds three rows of three columns; the new column enters on the right.
    function automatic logic [MASK_W-1:0] slide_window(logic [MASK_W-1:0] win, logic t,
                                                       logic m, logic b);
        return {b, win[8:7], m, win[5:4], t, win[2:1]};
    endfunction

    // Dilation matches the mirrored window against the element, erosion the window as given.
    function automatic logic window_result(logic [MASK_W-1:0] win);
        logic [MASK_W-1:0] mirrored;
        mirrored = {<<{win}};
        if (reg_mode == MODE_ERODE)
        begin
            return (win & reg_mask) == reg_mask;
        end
        return (mirrored & reg_mask) != '0;
    endfunction

    function automatic void predict_morphology(logic cmd_bit, logic pix_bit);
        int unsigned       w;
        int unsigned       h;
        int unsigned       col;
        int unsigned       total;
        logic              v;
        logic              top;
        logic              mid;
        logic [MASK_W-1:0] cand;
        bit                ready;
        bm3_result_t       res;
        w     = active_width();
        h     = active_height();
        total = w * h;
        col   = (next_col >= w) ? 0 : next_col;
        v     = (cmd_bit == CMD_PIXEL && next_row < h) ? pix_bit : 1'b0;
        top   = (next_row >= 2) ? line_older[col] : 1'b0;
        mid   = (next_row >= 1) ? line_prev[col] : 1'b0;
        if (col == 0)
        begin
            cand        = slide_window(window_bits, 1'b0, 1'b0, 1'b0);
            ready       = (next_row >= 2);
            window_bits = slide_window('0, top, mid, v);
        end
        else
        begin
            window_bits = slide_window(window_bits, top, mid, v);
            cand        = window_bits;
            ready       = (next_row >= 1);
        end
        line_older[col] = mid;
        line_prev[col]  = v;
        col++;
        if (col >= w)
        begin
            col = 0;
            next_row++;
        end
        next_col = col;
        if (ready && results_given < total)
        begin
            res.out_pixel = window_result(cand);
            res.frame_end = (results_given == total - 1);
            expected_pixels.push_back(res);
            results_given++;
            if (res.frame_end)
            begin
                restart_frame();
            end
        end
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 50)
        begin
            $display("%0t ns mismatch: %s", $time, msg);
        end
    endtask

    task automatic check_result(logic got_pixel, logic got_end);
        bm3_result_t want;
        if (expected_pixels.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result out_pixel=%b frame_end=%b",
                                      got_pixel, got_end));
            return;
        end
        want = expected_pixels.pop_front();
        if (got_pixel !== want.out_pixel)
        begin
            report_mismatch($sformatf("out_pixel %b, expected %b", got_pixel, want.out_pixel));
        end
        if (got_end !== want.frame_end)
        begin
            report_mismatch($sformatf("frame_end %b, expected %b", got_end, want.frame_end));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
            begin
                apply_register(cfg_index, cfg_data);
            end
            if (in_valid && !in_stall)
            begin
                predict_morphology(command, pixel);
            end
            if (out_valid && !out_stall)
            begin
                check_result(out_pixel, frame_end);
            end
        end
    end

    // Before each result the result side may stall: for a random gap, a hold-off, or not when steady.
    initial
    begin : result_sink
        int unsigned wait_cycles;
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            wait_cycles = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_off_cycles > 0)
            begin
                wait_cycles     = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic send_item(logic cmd_bit, logic pix_bit);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd_bit;
        pixel    <= pix_bit;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(bm3_cfg_idx_t idx, int unsigned value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Rows past the frame height are padding: drain items or surplus pixels.
    task automatic stream_items(int unsigned start_at, int unsigned count,
                                int unsigned density, int unsigned drain_pct,
                                int unsigned surplus_pct);
        int unsigned w;
        int unsigned h;
        int unsigned k;
        logic        cmd_bit;
        w = active_width();
        h = active_height();
        for (k = start_at; k < start_at + count; k++)
        begin
            if (k / w < h)
            begin
                cmd_bit = ($urandom_range(0, 99) < drain_pct) ? CMD_DRAIN : CMD_PIXEL;
            end
            else
            begin
                cmd_bit = ($urandom_range(0, 99) < surplus_pct) ? CMD_PIXEL : CMD_DRAIN;
            end
            send_item(cmd_bit, $urandom_range(0, 99) < density);
        end
    endtask

    function automatic int unsigned pick_mask();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 511;
            default: return $urandom_range(0, 511);
        endcase
    endfunction

    function automatic int unsigned pick_density();
        case ($urandom_range(0, 2))
            0: return 10;
            1: return 50;
            default: return 90;
        endcase
    endfunction

    task automatic test_reset_setting();
        settle();
        write_reg(CFG_WIDTH, 3);
        write_reg(CFG_HEIGHT, 2);
        stream_items(0, frame_items(), 50, 30, 50);
    endtask

    task automatic test_mask_extremes();
        settle();
        write_reg(CFG_MASK, 511);
        write_reg(CFG_MODE, MODE_DILATE);
        write_reg(CFG_WIDTH, 2);
        write_reg(CFG_HEIGHT, 2);
        stream_items(0, frame_items(), 30, 0, 50);
        settle();
        write_reg(CFG_MASK, 0);
        write_reg(CFG_MODE, MODE_ERODE);
        write_reg(CFG_HEIGHT, 1);
        stream_items(0, frame_items(), 50, 20, 50);
    endtask

    task automatic test_geometry_extremes();
        settle();
        write_reg(CFG_MASK, 186);
        write_reg(CFG_MODE, MODE_DILATE);
        write_reg(CFG_WIDTH, 0);
        write_reg(CFG_HEIGHT, 0);
        stream_items(0, frame_items(), 50, 0, 50);
        settle();
        steady = 1'b1;
        write_reg(CFG_MASK, 146);
        write_reg(CFG_MODE, MODE_ERODE);
        write_reg(CFG_WIDTH, 1);
        write_reg(CFG_HEIGHT, 6);
        stream_items(0, frame_items(), 80, 5, 50);
        settle();
        steady = 1'b0;
        write_reg(CFG_MASK, 56);
        write_reg(CFG_MODE, MODE_DILATE);
        write_reg(CFG_WIDTH, 12);
        write_reg(CFG_HEIGHT, 0);
        stream_items(0, frame_items(), 20, 5, 50);
    endtask

    // The result side holds off long enough for the block to stall its input.
    task automatic test_backpressure();
        settle();
        write_reg(CFG_MASK, pick_mask());
        write_reg(CFG_WIDTH, 5);
        write_reg(CFG_HEIGHT, 4);
        steady          = 1'b1;
        hold_off_cycles = HOLD_CYCLES;
        repeat (3) stream_items(0, frame_items(), 50, 0, 50);
        settle();
        steady = 1'b0;
    endtask

    task automatic test_random_frames();
        int unsigned first_item;
        int unsigned n;
        int unsigned cut;
        int unsigned density;
        int unsigned drain_pct;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS)
        begin
            settle();
            steady    = ($urandom_range(0, 4) == 0);
            density   = pick_density();
            drain_pct = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 50) : 0;
            write_reg(CFG_MASK, pick_mask());
            write_reg(CFG_MODE, $urandom_range(0, 1));
            write_reg(CFG_WIDTH, ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
                                                             : $urandom_range(1, 12));
            write_reg(CFG_HEIGHT, $urandom_range(1, 8));
            n = frame_items();
            case ($urandom_range(0, 9))
                0:
                begin
                    // An abandoned frame; the next geometry write restarts it.
                    stream_items(0, $urandom_range(1, n - 1), density, drain_pct, 50);
                end
                1, 2:
                begin
                    // The element and the operation change partway through a frame.
                    cut = $urandom_range(1, n - 1);
                    stream_items(0, cut, density, drain_pct, 50);
                    settle();
                    write_reg(CFG_MASK, pick_mask());
                    write_reg(CFG_MODE, $urandom_range(0, 1));
                    stream_items(cut, n - cut, density, drain_pct, 50);
                end
                default:
                begin
                    repeat ($urandom_range(1, 3)) stream_items(0, n, density, drain_pct, 50);
                end
            endcase
        end
        steady = 1'b0;
    endtask

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_MASK;
        cfg_data  = '0;
        in_valid  = 1'b0;
        command   = CMD_PIXEL;
        pixel     = 1'b0;
        reset_prediction();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_setting();
        test_mask_extremes();
        test_geometry_extremes();
        test_backpressure();
        test_random_frames();
        settle();
        if (mismatch_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ binary_morphology_3x3_top.f @@
rtl/bm3_pkg.sv
rtl/bm3_ram.sv
rtl/bm3_scan.sv
rtl/bm3_win.sv
rtl/bm3_oq.sv
rtl/binary_morphology_3x3_top.sv
dv/tb_binary_morphology_3x3_top.sv
